[sv/capacity_pool_round_robin_picker_unit_macros.svh]
// ----------------------------------------------------------------------------
// capacity pool picker assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef CAPACITY_POOL_ROUND_ROBIN_PICKER_UNIT_MACROS_SVH
`define CAPACITY_POOL_ROUND_ROBIN_PICKER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CPRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define CPRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[sv/cprr_pkg.sv]
// ----------------------------------------------------------------------------
// cprr_pkg
// constants, command and status types shared by the picker modules
// ----------------------------------------------------------------------------
package cprr_pkg;

  localparam int ID_BITS  = 8;
  localparam int ID_SPACE = 1 << ID_BITS;
  localparam int MAX_PICK = 16;
  localparam int CNT_W    = ID_BITS + 1;
  localparam int N_W      = $clog2(MAX_PICK + 1);
  localparam int TGT_W    = 8;
  localparam int REQ_W    = 5;

  // opcodes
  localparam logic [1:0] OP_ADD_OR_UPDATE = 2'd0;
  localparam logic [1:0] OP_ADD_IF_NEW    = 2'd1;
  localparam logic [1:0] OP_REMOVE        = 2'd2;
  localparam logic [1:0] OP_PICK          = 2'd3;

  // pool classes as stored
  localparam logic [1:0] CLS_NONE      = 2'd0;
  localparam logic [1:0] CLS_NORMAL    = 2'd1;
  localparam logic [1:0] CLS_LOW       = 2'd2;
  localparam logic [1:0] CLS_EMERGENCY = 2'd3;

  // result kinds
  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_OP   = 2'd1;
  localparam logic [1:0] EMIT_NULL = 2'd2;
  localparam logic [1:0] EMIT_PICK = 2'd3;

  typedef struct packed {
    logic       load;
    logic       rd;
    logic       addr_id;
    logic       upd;
    logic       psel;
    logic       probe_inc;
    logic       set_last;
    logic       cnt_inc;
    logic [1:0] emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       pool_empty;
    logic       hit;
    logic       n_zero;
    logic       last_pick;
  } status_t;

endpackage

[sv/cprr_ram.sv]
// ----------------------------------------------------------------------------
// cprr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cprr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/cprr_ctrl.sv]
// ----------------------------------------------------------------------------
// cprr_ctrl
// sequencer for pool updates and round-robin scans
// ----------------------------------------------------------------------------
module cprr_ctrl import cprr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD      = 3'd1;
  localparam logic [2:0] S_UPD     = 3'd2;
  localparam logic [2:0] S_PSEL    = 3'd3;
  localparam logic [2:0] S_START_A = 3'd4;
  localparam logic [2:0] S_START_C = 3'd5;
  localparam logic [2:0] S_STEP_A  = 3'd6;
  localparam logic [2:0] S_STEP_C  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (status.op == OP_PICK) begin
          state_next = S_PSEL;
        end else begin
          cmd.rd      = 1'b1;
          cmd.addr_id = 1'b1;
          state_next  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        cmd.emit   = EMIT_OP;
        state_next = S_IDLE;
      end
      S_PSEL: begin
        cmd.psel = 1'b1;
        if (status.pool_empty) begin
          cmd.emit   = EMIT_NULL;
          state_next = S_IDLE;
        end else begin
          state_next = S_START_A;
        end
      end
      S_START_A: begin
        cmd.rd     = 1'b1;
        state_next = S_START_C;
      end
      S_START_C: begin
        // first member at or after last_chosen, wrapping
        if (status.hit) begin
          if (status.n_zero) begin
            cmd.set_last = 1'b1;
            cmd.emit     = EMIT_NULL;
            state_next   = S_IDLE;
          end else begin
            cmd.probe_inc = 1'b1;
            state_next    = S_STEP_A;
          end
        end else begin
          cmd.probe_inc = 1'b1;
          state_next    = S_START_A;
        end
      end
      S_STEP_A: begin
        cmd.rd     = 1'b1;
        state_next = S_STEP_C;
      end
      S_STEP_C: begin
        cmd.probe_inc = 1'b1;
        if (status.hit) begin
          cmd.emit    = EMIT_PICK;
          cmd.cnt_inc = 1'b1;
          if (status.last_pick) begin
            cmd.set_last = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_STEP_A;
          end
        end else begin
          state_next = S_STEP_A;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/cprr_dp.sv]
// ----------------------------------------------------------------------------
// cprr_dp
// pool class store, pool counts, scan probe and result registers
// ----------------------------------------------------------------------------
module cprr_dp import cprr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [1:0]       opcode,
  input  logic [7:0]       target_id,
  input  logic [1:0]       pool_type,
  input  logic [REQ_W-1:0] pick_count,
  output status_t          status,
  output logic             result_valid,
  output logic             flag,
  output logic             found,
  output logic [TGT_W-1:0] chosen_target,
  output logic             last_of_run
);

  logic [1:0]         op_q;
  logic [ID_BITS-1:0] id_q;
  logic [1:0]         cls_q;
  logic [REQ_W-1:0]   req_q;
  logic [1:0]         pool_q;
  logic [N_W-1:0]     n_q;
  logic [N_W-1:0]     cnt_q;
  logic [ID_BITS-1:0] probe;
  logic [ID_BITS-1:0] last_chosen;
  logic [CNT_W-1:0]   normal_count;
  logic [CNT_W-1:0]   low_count;
  logic [CNT_W-1:0]   emergency_count;
  logic [ID_SPACE-1:0] valid;
  logic               vld_q;

  logic [ID_BITS-1:0] raddr;
  logic [1:0]         ram_q;
  logic [1:0]         cls_rd;
  logic [1:0]         cls_new;
  logic               flag_c;
  logic [1:0]         pool_c;
  logic [CNT_W-1:0]   size_c;
  logic [CNT_W-1:0]   n_c;
  logic [CNT_W-1:0]   req_ext;

  assign raddr  = cmd.addr_id ? id_q : probe;
  // never-written entries read as no pool
  assign cls_rd = vld_q ? ram_q : CLS_NONE;

  cprr_ram #(
    .WIDTH (2),
    .DEPTH (ID_SPACE)
  ) u_class_ram (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (id_q),
    .wdata (cls_new),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // new class and flag for the update operations
  always_comb begin
    cls_new = cls_rd;
    flag_c  = 1'b0;
    case (op_q)
      OP_ADD_OR_UPDATE: begin
        cls_new = cls_q;
        flag_c  = (cls_rd != cls_q);
      end
      OP_ADD_IF_NEW: begin
        flag_c = (cls_rd == CLS_NONE);
        if (cls_rd == CLS_NONE) begin
          cls_new = cls_q;
        end
      end
      OP_REMOVE: begin
        cls_new = CLS_NONE;
      end
      default: begin
        cls_new = cls_rd;
      end
    endcase
  end

  // pool choice and run length
  always_comb begin
    req_ext = CNT_W'(req_q);
    if (normal_count != '0) begin
      pool_c = CLS_NORMAL;
      size_c = normal_count;
    end else if (low_count != '0) begin
      pool_c = CLS_LOW;
      size_c = low_count;
    end else begin
      pool_c = CLS_EMERGENCY;
      size_c = emergency_count;
    end
    n_c = size_c;
    if (req_ext < n_c) begin
      n_c = req_ext;
    end
    if (n_c > CNT_W'(MAX_PICK)) begin
      n_c = CNT_W'(MAX_PICK);
    end
  end

  assign status.op         = op_q;
  assign status.pool_empty = (size_c == '0);
  assign status.hit        = (cls_rd == pool_q);
  assign status.n_zero     = (n_q == '0);
  assign status.last_pick  = (N_W'(cnt_q + 1'b1) == n_q);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      id_q  <= target_id[ID_BITS-1:0];
      cls_q <= (pool_type >= 2'd2) ? CLS_EMERGENCY : (pool_type + 2'd1);
      req_q <= pick_count;
    end
    if (cmd.rd) begin
      vld_q <= valid[raddr];
    end
    if (cmd.psel) begin
      pool_q <= pool_c;
      n_q    <= N_W'(n_c);
      cnt_q  <= '0;
      probe  <= last_chosen;
    end
    if (cmd.probe_inc) begin
      probe <= probe + 1'b1;
    end
    if (cmd.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // control state: counts, valid bits, last chosen, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_count    <= '0;
      low_count       <= '0;
      emergency_count <= '0;
      valid           <= '0;
      last_chosen     <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cmd.upd) begin
        valid[id_q] <= 1'b1;
        if (cls_new != cls_rd) begin
          case (cls_rd)
            CLS_NORMAL:    normal_count    <= normal_count - 1'b1;
            CLS_LOW:       low_count       <= low_count - 1'b1;
            CLS_EMERGENCY: emergency_count <= emergency_count - 1'b1;
            default: begin
            end
          endcase
          case (cls_new)
            CLS_NORMAL:    normal_count    <= normal_count + 1'b1;
            CLS_LOW:       low_count       <= low_count + 1'b1;
            CLS_EMERGENCY: emergency_count <= emergency_count + 1'b1;
            default: begin
            end
          endcase
        end
      end
      if (cmd.set_last) begin
        last_chosen <= probe;
      end
      result_valid <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_OP: begin
        flag          <= flag_c;
        found         <= 1'b0;
        chosen_target <= '0;
        last_of_run   <= 1'b1;
      end
      EMIT_NULL: begin
        flag          <= 1'b0;
        found         <= 1'b0;
        chosen_target <= '0;
        last_of_run   <= 1'b1;
      end
      EMIT_PICK: begin
        flag          <= 1'b0;
        found         <= 1'b1;
        chosen_target <= TGT_W'(probe);
        last_of_run   <= status.last_pick;
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/capacity_pool_round_robin_picker_unit.sv]
// ----------------------------------------------------------------------------
// capacity_pool_round_robin_picker_unit
// per-target pool membership with round-robin picking from the first
// non-empty pool
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; results leave on
// result_valid for one cycle each and cannot be held off, so the block only
// ever produces them at its own pace. Add and remove read the class ram, then
// update it, and register the result. A pick selects the pool, then probes the
// class ram one entry at a time, each probe a read and then a compare: one
// probe pass from last_chosen to the start member, then one pass per result
// to the next member over a run of n results. n never exceeds the pool size,
// so the result passes cover at most one lap of the table. The single read
// port of the class ram is why entries are probed one at a time. There is no
// clearing pass: per-entry valid bits make untouched entries read as no pool
// straight out of reset.
// ----------------------------------------------------------------------------
`include "capacity_pool_round_robin_picker_unit_macros.svh"

module capacity_pool_round_robin_picker_unit import cprr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode,
  input  logic [7:0]       target_id,
  input  logic [1:0]       pool_type,
  input  logic [REQ_W-1:0] pick_count,
  output logic             result_valid,
  output logic             flag,
  output logic             found,
  output logic [TGT_W-1:0] chosen_target,
  output logic             last_of_run
);

  cmd_t    cmd;
  status_t status;

  cprr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  cprr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (opcode),
    .target_id     (target_id),
    .pool_type     (pool_type),
    .pick_count    (pick_count),
    .status        (status),
    .result_valid  (result_valid),
    .flag          (flag),
    .found         (found),
    .chosen_target (chosen_target),
    .last_of_run   (last_of_run)
  );

  // accepted transaction keeps the block busy until its last result
  `CPRR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // returning to idle always coincides with the final result
  `CPRR_ASSERT_IMP(a_idle_on_last, $fell(busy), result_valid && last_of_run)
  // only pick results can be followed by more results
  `CPRR_ASSERT_IMP(a_mid_run_pick, result_valid && !last_of_run, found && !flag)

endmodule
